@@ sv/bls_pkg.sv @@
// ----------------------------------------------------------------------------
// bls_pkg: shared types and constants for the Bresenham line stepper
// Coordinate widths, stream packing widths and the command word that
// travels from the setup front end to the stepping back end.
// ----------------------------------------------------------------------------
package bls_pkg;

  localparam int COORD_BITS = 12;
  localparam int COLOR_BITS = 32;
  localparam int TDM_BITS   = COORD_BITS + 1;  // 2*|d_minor|
  localparam int ERR_BITS   = COORD_BITS + 2;  // error term, two's complement

  localparam int IN_FIELD_BITS  = 4 * COORD_BITS + COLOR_BITS;
  localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = 2 * COORD_BITS + COLOR_BITS;
  localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

  localparam int FIFO_AW    = 1;
  localparam int FIFO_DEPTH = 1 << FIFO_AW;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COLOR_BITS-1:0] color_t;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_STEP = 1'b1
  } action_t;

  typedef struct packed {
    action_t               action;
    logic                  steep;
    coord_t                major_pos;
    coord_t                minor_pos;
    coord_t                major_end;
    coord_t                delta_major;
    logic [TDM_BITS-1:0]   twice_dminor;
    logic                  step_down;
    color_t                color;
  } bls_cmd_t;

endpackage

@@ sv/bls_front.sv @@
// ----------------------------------------------------------------------------
// bls_front: input classification and line setup
// Unpacks an input transfer, decides steepness, orders the endpoints and
// builds the command word pushed into the command queue.
// ----------------------------------------------------------------------------
module bls_front import bls_pkg::*; (
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_TDATA_BITS-1:0] in_tdata,
  input  logic                     in_tuser,
  output logic                     cmd_push,
  output bls_cmd_t                 cmd_data,
  input  logic                     cmd_full
);

  coord_t xa, ya, xb, yb;
  coord_t dx_abs, dy_abs;
  coord_t ma, na, mb, nb;
  logic   steep;
  logic   swap_ends;

  always_comb begin
    xa = in_tdata[COORD_BITS-1:0];
    ya = in_tdata[2*COORD_BITS-1:COORD_BITS];
    xb = in_tdata[3*COORD_BITS-1:2*COORD_BITS];
    yb = in_tdata[4*COORD_BITS-1:3*COORD_BITS];

    dx_abs = (xa > xb) ? (xa - xb) : (xb - xa);
    dy_abs = (ya > yb) ? (ya - yb) : (yb - ya);
    steep  = (dx_abs < dy_abs);  // equal slopes stay shallow

    swap_ends = steep ? (ya > yb) : (xa > xb);
    if (steep) begin
      ma = swap_ends ? yb : ya;
      mb = swap_ends ? ya : yb;
      na = swap_ends ? xb : xa;
      nb = swap_ends ? xa : xb;
    end else begin
      ma = swap_ends ? xb : xa;
      mb = swap_ends ? xa : xb;
      na = swap_ends ? yb : ya;
      nb = swap_ends ? ya : yb;
    end

    cmd_data.action       = action_t'(in_tuser);
    cmd_data.steep        = steep;
    cmd_data.major_pos    = ma;
    cmd_data.minor_pos    = na;
    cmd_data.major_end    = mb;
    cmd_data.delta_major  = steep ? dy_abs : dx_abs;
    cmd_data.twice_dminor = {(steep ? dx_abs : dy_abs), 1'b0};
    cmd_data.step_down    = !(nb > na);
    cmd_data.color        = in_tdata[IN_FIELD_BITS-1:4*COORD_BITS];
  end

  assign in_tready = !cmd_full;
  assign cmd_push  = in_tvalid && !cmd_full;

endmodule

@@ sv/bls_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// bls_cmd_fifo: command queue between setup and stepping
// Small flop-based FIFO; lets the front end keep accepting while the back
// end waits on the output channel.
// ----------------------------------------------------------------------------
module bls_cmd_fifo import bls_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  bls_cmd_t wdata,
  output logic     full,
  input  logic     pop,
  output bls_cmd_t rdata,
  output logic     not_empty
);

  bls_cmd_t             mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]     count_r, count_nxt;

  assign full      = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign not_empty = (count_r != '0);
  assign rdata     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("command queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from empty command queue");
`endif

endmodule

@@ sv/bls_back.sv @@
// ----------------------------------------------------------------------------
// bls_back: Bresenham stepping engine
// Holds the active line, executes load and step commands and drives the
// registered output stage.
// ----------------------------------------------------------------------------
module bls_back import bls_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cmd_valid,
  input  bls_cmd_t cmd_data,
  output logic     cmd_pop,
  output logic     out_valid,
  input  logic     out_ready,
  output coord_t   pix_x,
  output coord_t   pix_y,
  output color_t   pix_color,
  output logic     pix_last
);

  logic                active_r, active_nxt;
  logic                steep_r, steep_nxt;
  coord_t              major_r, major_nxt;
  coord_t              minor_r, minor_nxt;
  coord_t              end_r, end_nxt;
  coord_t              dmaj_r, dmaj_nxt;
  logic [TDM_BITS-1:0] tdm_r, tdm_nxt;
  logic                down_r, down_nxt;
  logic [ERR_BITS-1:0] err_r, err_nxt;
  color_t              color_r, color_nxt;

  logic                out_valid_r, out_valid_nxt;
  coord_t              px_r, py_r;
  color_t              pc_r;
  logic                plast_r;

  logic                is_step, slot_free, emit, at_end;
  logic [ERR_BITS-1:0] err_sum, err_adj;

  always_comb begin
    is_step   = (cmd_data.action == ACT_STEP);
    slot_free = !out_valid_r || out_ready;
    cmd_pop   = cmd_valid && (!is_step || !active_r || slot_free);
    emit      = cmd_valid && is_step && active_r && slot_free;
    at_end    = (major_r == end_r);
    err_sum   = err_r + ERR_BITS'(tdm_r);
    err_adj   = err_sum - ERR_BITS'({dmaj_r, 1'b0});

    active_nxt = active_r;
    steep_nxt  = steep_r;
    major_nxt  = major_r;
    minor_nxt  = minor_r;
    end_nxt    = end_r;
    dmaj_nxt   = dmaj_r;
    tdm_nxt    = tdm_r;
    down_nxt   = down_r;
    err_nxt    = err_r;
    color_nxt  = color_r;

    if (cmd_valid && !is_step) begin
      active_nxt = 1'b1;
      steep_nxt  = cmd_data.steep;
      major_nxt  = cmd_data.major_pos;
      minor_nxt  = cmd_data.minor_pos;
      end_nxt    = cmd_data.major_end;
      dmaj_nxt   = cmd_data.delta_major;
      tdm_nxt    = cmd_data.twice_dminor;
      down_nxt   = cmd_data.step_down;
      err_nxt    = ERR_BITS'(0) - ERR_BITS'(cmd_data.delta_major);
      color_nxt  = cmd_data.color;
    end else if (emit) begin
      if (at_end) begin
        active_nxt = 1'b0;
      end else begin
        major_nxt = major_r + 1'b1;
        if (!err_sum[ERR_BITS-1]) begin
          err_nxt   = err_adj;
          minor_nxt = down_r ? minor_r - 1'b1 : minor_r + 1'b1;
        end else begin
          err_nxt = err_sum;
        end
      end
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      steep_r     <= 1'b0;
      major_r     <= '0;
      minor_r     <= '0;
      end_r       <= '0;
      dmaj_r      <= '0;
      tdm_r       <= '0;
      down_r      <= 1'b0;
      err_r       <= '0;
      color_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      steep_r     <= steep_nxt;
      major_r     <= major_nxt;
      minor_r     <= minor_nxt;
      end_r       <= end_nxt;
      dmaj_r      <= dmaj_nxt;
      tdm_r       <= tdm_nxt;
      down_r      <= down_nxt;
      err_r       <= err_nxt;
      color_r     <= color_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload, no reset
  always_ff @(posedge clk) begin
    if (emit) begin
      px_r    <= steep_r ? minor_r : major_r;
      py_r    <= steep_r ? major_r : minor_r;
      pc_r    <= color_r;
      plast_r <= at_end;
    end
  end

  assign out_valid = out_valid_r;
  assign pix_x     = px_r;
  assign pix_y     = py_r;
  assign pix_color = pc_r;
  assign pix_last  = plast_r;

`ifndef ASSERT_OFF
  a_major_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (major_r <= end_r))
    else $error("major coordinate passed the line end");

  a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && at_end && !(cmd_valid && !is_step)) |=> !active_r)
    else $error("line still active after its end point");

  a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !emit)
    else $error("pixel overwrote a stalled output");
`endif

endmodule

@@ sv/bresenham_line_stepper.sv @@
// ----------------------------------------------------------------------------
// bresenham_line_stepper: integer Bresenham line engine
// Loads a line with its colour, then emits one pixel per step transfer.
// Usage:
//   Input stream (in_*): in_tuser selects the action, 0 loads a line from
//   the endpoints and colour in in_tdata, 1 steps and requests one pixel.
//   A load gives no output; it replaces any line in progress. A step with
//   no active line is consumed and gives nothing.
//   Output stream (out_*): one pixel per step while a line is active, in
//   the original x/y order with the latched colour. Both endpoints are
//   drawn; the end point carries out_tlast and ends the line.
//   A step passes through the command queue and then the output register
//   before its pixel shows on out_tvalid.
//   Throughput: one transfer per cycle on both sides while out_tready is
//   high, set by the single stepping update in the back end.
//   Reset (rst_n low, synchronous) drops any active line and empties the
//   command queue. When the receiver stalls, the output register holds
//   its pixel and the two-entry command queue keeps taking transfers until
//   it fills, then in_tready falls.
// ----------------------------------------------------------------------------
module bresenham_line_stepper import bls_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // x_start, y_start, x_end, y_end, line_color (from bit 0 up)
  input  logic [IN_TDATA_BITS-1:0]  in_tdata,
  // action
  input  logic                      in_tuser,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // pixel_x, pixel_y, pixel_color (from bit 0 up), zero padded to bytes
  output logic [OUT_TDATA_BITS-1:0] out_tdata,
  output logic                      out_tlast
);

  // front end -> queue
  logic     cmd_push, cmd_full;
  bls_cmd_t cmd_wdata;

  // queue -> back end
  logic     cmd_pop, cmd_valid;
  bls_cmd_t cmd_rdata;

  // back end pixel fields
  coord_t   pix_x, pix_y;
  color_t   pix_color;

  // Setup: steepness, endpoint order, deltas, minor direction.
  bls_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_push  (cmd_push),
    .cmd_data  (cmd_wdata),
    .cmd_full  (cmd_full)
  );

  // Decouples setup from stepping so a stalled output does not block input
  // transfers immediately.
  bls_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .wdata     (cmd_wdata),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .rdata     (cmd_rdata),
    .not_empty (cmd_valid)
  );

  // Line state, error update and registered pixel output.
  bls_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_data  (cmd_rdata),
    .cmd_pop   (cmd_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .pix_x     (pix_x),
    .pix_y     (pix_y),
    .pix_color (pix_color),
    .pix_last  (out_tlast)
  );

  // Pack output fields; any byte padding stays zero.
  always_comb begin
    out_tdata = '0;
    out_tdata[COORD_BITS-1:0]                = pix_x;
    out_tdata[2*COORD_BITS-1:COORD_BITS]     = pix_y;
    out_tdata[OUT_FIELD_BITS-1:2*COORD_BITS] = pix_color;
  end

endmodule
